// ===== rtl/sba_pkg.sv =====
// Shared types, codes and helper functions of the sharded bitmap allocator.
`default_nettype none
package sba_pkg;

  localparam int WORD_BITS     = 64;
  localparam int BIT_IDX_W     = 6;
  localparam int MAX_WORDS_DEF = 64;
  localparam int CFG_W         = 7;
  localparam int FUNC_W        = 3;
  localparam int HINT_W        = 12;
  localparam int BEGIN_W       = 12;
  localparam int END_W         = 13;
  localparam int TARGET_W      = 12;
  localparam int STATUS_W      = 2;
  localparam int CBIT_W        = 12;
  localparam int CWORD_W       = 6;
  localparam int PROBED_W      = 7;

  localparam logic [CFG_W-1:0] ACTIVE_RESET = 7'd64;

  localparam logic [FUNC_W-1:0] FN_ALLOC_ANY   = 3'd0;
  localparam logic [FUNC_W-1:0] FN_ALLOC_RANGE = 3'd1;
  localparam logic [FUNC_W-1:0] FN_SET_RANGE   = 3'd2;
  localparam logic [FUNC_W-1:0] FN_CLEAR_BIT   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_TEST_BIT    = 3'd4;

  localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_INVALID   = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_EXHAUSTED = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_DBL_CLEAR = 2'd3;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_A0_RD,
    S_A0_CK,
    S_A1_RD,
    S_A1_CK,
    S_SR_RD,
    S_SR_WR,
    S_BIT_RD,
    S_BIT_CK
  } sba_state_t;

  function automatic word_t low_mask(input logic [CFG_W-1:0] n);
    word_t m;
    m = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      m[i] = (CFG_W'(i) < n);
    end
    return m;
  endfunction

  function automatic logic [BIT_IDX_W-1:0] lowest_set(input word_t v);
    logic [BIT_IDX_W-1:0] idx;
    idx = BIT_IDX_W'(WORD_BITS - 1);
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = BIT_IDX_W'(i);
      end
    end
    return idx;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/sharded_bitmap_allocator_top.sv =====
// Top level of the sharded bitmap allocator: control sequencer around the bitmap RAM.
// Invalid requests and unknown functions strobe their result in the cycle after acceptance.
// Allocate-any first computes the start-word modulo, then reads and checks each word probed.
// Ranged allocate and set-range read, then check or write, each word; clear and test do so for one word.
// Other results strobe in the first cycle with busy low again.
// After reset a clearing pass zeroes all MAX_WORDS words of the bitmap while busy is high.
`default_nettype none
module sharded_bitmap_allocator_top
  import sba_pkg::*;
#(
  parameter int MAX_WORDS = MAX_WORDS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [FUNC_W-1:0]     in_func,
  input  wire logic [HINT_W-1:0]     in_hint,
  input  wire logic [BEGIN_W-1:0]    in_range_begin,
  input  wire logic [END_W-1:0]      in_range_end,
  input  wire logic [TARGET_W-1:0]   in_target_bit,
  output logic                       out_valid,
  output logic [STATUS_W-1:0]        out_status,
  output logic [CBIT_W-1:0]          out_claimed_bit,
  output logic [CWORD_W-1:0]         out_claimed_word,
  output logic [PROBED_W-1:0]        out_words_probed,
  output logic                       out_bit_is_set,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_W-1:0]      cfg_wdata
);

  localparam int AW      = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int WCAP    = (MAX_WORDS < 127) ? MAX_WORDS : 127;
  localparam int MODCW   = $clog2(HINT_W);

  sba_state_t state_r, state_nxt;

  logic [CFG_W-1:0]     active_r;
  logic [AW-1:0]        clr_addr_r, clr_addr_nxt;
  logic [FUNC_W-1:0]    op_r, op_nxt;
  logic [CFG_W-1:0]     cur_w_r, cur_w_nxt;
  logic [CFG_W-1:0]     first_w_r, first_w_nxt;
  logic [CFG_W-1:0]     last_w_r, last_w_nxt;
  logic [CFG_W-1:0]     span_r, span_nxt;
  logic [CFG_W-1:0]     cnt_r, cnt_nxt;
  logic [BIT_IDX_W-1:0] lo_r, lo_nxt;
  logic [CFG_W-1:0]     hi_r, hi_nxt;
  logic [BIT_IDX_W-1:0] bit_r, bit_nxt;
  logic [HINT_W-1:0]    hint_sh_r, hint_sh_nxt;
  logic [CFG_W-1:0]     rem_r, rem_nxt;
  logic [MODCW-1:0]     mod_cnt_r, mod_cnt_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]  out_status_r, out_status_nxt;
  logic [CBIT_W-1:0]    out_claimed_bit_r, out_claimed_bit_nxt;
  logic [CWORD_W-1:0]   out_claimed_word_r, out_claimed_word_nxt;
  logic [PROBED_W-1:0]  out_words_probed_r, out_words_probed_nxt;
  logic                 out_bit_is_set_r, out_bit_is_set_nxt;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  word_t                ram_wdata;
  word_t                ram_rdata;

  logic [CFG_W-1:0]     words;
  logic [END_W-1:0]     total;
  logic                 accept;
  logic [END_W-1:0]     end_m1;
  logic                 range_bad;
  logic                 tgt_bad;
  logic                 hint_out;
  logic [HINT_W-1:0]    hint_eff;
  logic [CFG_W+1-1:0]   mod_t;
  logic                 mod_ge;
  logic [CFG_W-1:0]     mod_rem;
  logic                 mod_last;
  logic [CFG_W-1:0]     cnt_inc;
  logic                 a0_hit;
  logic [BIT_IDX_W-1:0] a0_bit;
  logic                 a0_done;
  logic [CFG_W-1:0]     lo_eff;
  logic [CFG_W-1:0]     hi_eff;
  word_t                range_mask;
  word_t                avail;
  word_t                after;
  word_t                cand;
  logic                 a1_hit;
  logic [BIT_IDX_W-1:0] a1_bit;
  logic                 a1_done;
  logic                 sr_done;
  logic                 bit_val;

  assign words = (active_r == '0) ? CFG_W'(1) :
                 ((active_r > CFG_W'(WCAP)) ? CFG_W'(WCAP) : active_r);
  assign total = {words, BIT_IDX_W'(0)};
  assign busy = (state_r != S_IDLE);
  assign accept = start && !busy;

  assign end_m1 = in_range_end - END_W'(1);
  assign range_bad = ({1'b0, in_range_begin} >= in_range_end) || (in_range_end > total);
  assign tgt_bad = ({1'b0, in_target_bit} >= total);
  assign hint_out = (in_hint < in_range_begin) || ({1'b0, in_hint} >= in_range_end);
  assign hint_eff = hint_out ? in_range_begin : in_hint;

  assign mod_t = {rem_r, hint_sh_r[HINT_W-1]};
  assign mod_ge = (mod_t >= {1'b0, words});
  assign mod_rem = mod_ge ? CFG_W'(mod_t - {1'b0, words}) : mod_t[CFG_W-1:0];
  assign mod_last = (mod_cnt_r == MODCW'(HINT_W - 1));

  assign cnt_inc = cnt_r + CFG_W'(1);

  assign a0_hit = (ram_rdata != '1);
  assign a0_bit = lowest_set(~ram_rdata);
  assign a0_done = (cnt_inc == words);

  assign lo_eff = (cur_w_r == first_w_r) ? {1'b0, lo_r} : '0;
  assign hi_eff = (cur_w_r == last_w_r) ? hi_r : CFG_W'(WORD_BITS);
  assign range_mask = low_mask(hi_eff) & ~low_mask(lo_eff);
  assign avail = ~ram_rdata & range_mask;
  assign after = avail & ~low_mask({1'b0, bit_r});
  assign cand = ((cnt_r == '0) && (after != '0)) ? after : avail;
  assign a1_hit = (avail != '0);
  assign a1_bit = lowest_set(cand);
  assign a1_done = (cnt_inc == span_r);

  assign sr_done = (cur_w_r == last_w_r);
  assign bit_val = ram_rdata[bit_r];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_addr_r == AW'(MAX_WORDS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          case (in_func)
            FN_ALLOC_ANY:   state_nxt = S_MOD;
            FN_ALLOC_RANGE: state_nxt = range_bad ? S_IDLE : S_A1_RD;
            FN_SET_RANGE:   state_nxt = range_bad ? S_IDLE : S_SR_RD;
            FN_CLEAR_BIT,
            FN_TEST_BIT:    state_nxt = tgt_bad ? S_IDLE : S_BIT_RD;
            default:        state_nxt = S_IDLE;
          endcase
        end
      end
      S_MOD:    state_nxt = mod_last ? S_A0_RD : S_MOD;
      S_A0_RD:  state_nxt = S_A0_CK;
      S_A0_CK:  state_nxt = (a0_hit || a0_done) ? S_IDLE : S_A0_RD;
      S_A1_RD:  state_nxt = S_A1_CK;
      S_A1_CK:  state_nxt = (a1_hit || a1_done) ? S_IDLE : S_A1_RD;
      S_SR_RD:  state_nxt = S_SR_WR;
      S_SR_WR:  state_nxt = sr_done ? S_IDLE : S_SR_RD;
      S_BIT_RD: state_nxt = S_BIT_CK;
      S_BIT_CK: state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    clr_addr_nxt = clr_addr_r;
    op_nxt = op_r;
    cur_w_nxt = cur_w_r;
    first_w_nxt = first_w_r;
    last_w_nxt = last_w_r;
    span_nxt = span_r;
    cnt_nxt = cnt_r;
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    bit_nxt = bit_r;
    hint_sh_nxt = hint_sh_r;
    rem_nxt = rem_r;
    mod_cnt_nxt = mod_cnt_r;
    out_valid_nxt = 1'b0;
    out_status_nxt = out_status_r;
    out_claimed_bit_nxt = out_claimed_bit_r;
    out_claimed_word_nxt = out_claimed_word_r;
    out_words_probed_nxt = out_words_probed_r;
    out_bit_is_set_nxt = out_bit_is_set_r;
    ram_we = 1'b0;
    ram_waddr = AW'(cur_w_r);
    ram_wdata = ram_rdata;
    case (state_r)
      S_CLEAR: begin
        ram_we = 1'b1;
        ram_waddr = clr_addr_r;
        ram_wdata = '0;
        clr_addr_nxt = clr_addr_r + AW'(1);
      end
      S_IDLE: begin
        if (accept) begin
          op_nxt = in_func;
          cnt_nxt = '0;
          rem_nxt = '0;
          mod_cnt_nxt = '0;
          hint_sh_nxt = in_hint;
          first_w_nxt = {1'b0, in_range_begin[BEGIN_W-1:BIT_IDX_W]};
          last_w_nxt = end_m1[END_W-1:BIT_IDX_W];
          span_nxt = CFG_W'(end_m1[END_W-1:BIT_IDX_W]
                     - {1'b0, in_range_begin[BEGIN_W-1:BIT_IDX_W]} + CFG_W'(1));
          lo_nxt = in_range_begin[BIT_IDX_W-1:0];
          hi_nxt = {1'b0, end_m1[BIT_IDX_W-1:0]} + CFG_W'(1);
          case (in_func)
            FN_ALLOC_RANGE: begin
              cur_w_nxt = {1'b0, hint_eff[HINT_W-1:BIT_IDX_W]};
              bit_nxt = hint_eff[BIT_IDX_W-1:0];
            end
            FN_SET_RANGE: begin
              cur_w_nxt = {1'b0, in_range_begin[BEGIN_W-1:BIT_IDX_W]};
            end
            default: begin
              cur_w_nxt = {1'b0, in_target_bit[TARGET_W-1:BIT_IDX_W]};
              bit_nxt = in_target_bit[BIT_IDX_W-1:0];
            end
          endcase
          if ((in_func == FN_ALLOC_RANGE && range_bad) ||
              (in_func == FN_SET_RANGE && range_bad) ||
              ((in_func inside {FN_CLEAR_BIT, FN_TEST_BIT}) && tgt_bad) ||
              (in_func > FN_TEST_BIT)) begin
            out_valid_nxt = 1'b1;
            out_status_nxt = STAT_INVALID;
            out_claimed_bit_nxt = '0;
            out_claimed_word_nxt = '0;
            out_words_probed_nxt = '0;
            out_bit_is_set_nxt = 1'b0;
          end
        end
      end
      S_MOD: begin
        rem_nxt = mod_rem;
        hint_sh_nxt = {hint_sh_r[HINT_W-2:0], 1'b0};
        mod_cnt_nxt = mod_cnt_r + MODCW'(1);
        if (mod_last) begin
          cur_w_nxt = mod_rem;
        end
      end
      S_A0_CK: begin
        if (a0_hit) begin
          ram_we = 1'b1;
          ram_wdata = ram_rdata | (word_t'(1) << a0_bit);
          out_valid_nxt = 1'b1;
          out_status_nxt = STAT_OK;
          out_claimed_bit_nxt = {cur_w_r[CWORD_W-1:0], a0_bit};
          out_claimed_word_nxt = cur_w_r[CWORD_W-1:0];
          out_words_probed_nxt = '0;
          out_bit_is_set_nxt = 1'b0;
        end else begin
          cnt_nxt = cnt_inc;
          cur_w_nxt = (cur_w_r == words - CFG_W'(1)) ? '0 : cur_w_r + CFG_W'(1);
          if (a0_done) begin
            out_valid_nxt = 1'b1;
            out_status_nxt = STAT_EXHAUSTED;
            out_claimed_bit_nxt = '0;
            out_claimed_word_nxt = '0;
            out_words_probed_nxt = '0;
            out_bit_is_set_nxt = 1'b0;
          end
        end
      end
      S_A1_CK: begin
        if (a1_hit) begin
          ram_we = 1'b1;
          ram_wdata = ram_rdata | (word_t'(1) << a1_bit);
          out_valid_nxt = 1'b1;
          out_status_nxt = STAT_OK;
          out_claimed_bit_nxt = {cur_w_r[CWORD_W-1:0], a1_bit};
          out_claimed_word_nxt = cur_w_r[CWORD_W-1:0];
          out_words_probed_nxt = cnt_inc;
          out_bit_is_set_nxt = 1'b0;
        end else begin
          cnt_nxt = cnt_inc;
          cur_w_nxt = (cur_w_r == last_w_r) ? first_w_r : cur_w_r + CFG_W'(1);
          if (a1_done) begin
            out_valid_nxt = 1'b1;
            out_status_nxt = STAT_EXHAUSTED;
            out_claimed_bit_nxt = '0;
            out_claimed_word_nxt = '0;
            out_words_probed_nxt = span_r;
            out_bit_is_set_nxt = 1'b0;
          end
        end
      end
      S_SR_WR: begin
        ram_we = 1'b1;
        ram_wdata = ram_rdata | range_mask;
        cur_w_nxt = cur_w_r + CFG_W'(1);
        if (sr_done) begin
          out_valid_nxt = 1'b1;
          out_status_nxt = STAT_OK;
          out_claimed_bit_nxt = '0;
          out_claimed_word_nxt = '0;
          out_words_probed_nxt = '0;
          out_bit_is_set_nxt = 1'b0;
        end
      end
      S_BIT_CK: begin
        out_valid_nxt = 1'b1;
        out_claimed_bit_nxt = '0;
        out_claimed_word_nxt = '0;
        out_words_probed_nxt = '0;
        if (op_r == FN_CLEAR_BIT) begin
          out_bit_is_set_nxt = 1'b0;
          if (bit_val) begin
            ram_we = 1'b1;
            ram_wdata = ram_rdata & ~(word_t'(1) << bit_r);
            out_status_nxt = STAT_OK;
          end else begin
            out_status_nxt = STAT_DBL_CLEAR;
          end
        end else begin
          out_status_nxt = STAT_OK;
          out_bit_is_set_nxt = bit_val;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      active_r <= ACTIVE_RESET;
      clr_addr_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        active_r <= cfg_wdata;
      end
      clr_addr_r <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt;
    cur_w_r <= cur_w_nxt;
    first_w_r <= first_w_nxt;
    last_w_r <= last_w_nxt;
    span_r <= span_nxt;
    cnt_r <= cnt_nxt;
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
    bit_r <= bit_nxt;
    hint_sh_r <= hint_sh_nxt;
    rem_r <= rem_nxt;
    mod_cnt_r <= mod_cnt_nxt;
    out_status_r <= out_status_nxt;
    out_claimed_bit_r <= out_claimed_bit_nxt;
    out_claimed_word_r <= out_claimed_word_nxt;
    out_words_probed_r <= out_words_probed_nxt;
    out_bit_is_set_r <= out_bit_is_set_nxt;
  end

  sba_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(MAX_WORDS)
  ) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (AW'(cur_w_r)),
    .rdata (ram_rdata)
  );

  assign out_valid = out_valid_r;
  assign out_status = out_status_r;
  assign out_claimed_bit = out_claimed_bit_r;
  assign out_claimed_word = out_claimed_word_r;
  assign out_words_probed = out_words_probed_r;
  assign out_bit_is_set = out_bit_is_set_r;

  // Every accepted transaction either keeps the block busy or reports at once.
  assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (busy || out_valid))
    else $error("accepted transaction produced neither work nor a result");

  // The bitmap is only written during the clearing pass or a modify step.
  assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_CLEAR || state_r == S_A0_CK || state_r == S_A1_CK ||
                state_r == S_SR_WR || state_r == S_BIT_CK))
    else $error("bitmap write outside a modify step");

  // A successful claim names a bit inside the reported word.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STAT_OK) |->
      (out_claimed_word == out_claimed_bit[CBIT_W-1:BIT_IDX_W]))
    else $error("claimed bit and claimed word disagree");

  // No result can appear while the clearing pass is still running.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(state_r) != S_CLEAR))
    else $error("result reported during the clearing pass");

  // An exhausted allocation reports no claimed bit.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STAT_EXHAUSTED) |->
      (out_claimed_bit == '0 && out_claimed_word == '0))
    else $error("exhausted result carries a claimed bit");

endmodule
`default_nettype wire

// ===== rtl/sba_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none
module sba_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== bench/sharded_bitmap_allocator_top_test.sv =====
// Self-checking testbench for the sharded bitmap allocator, checked against a shadow bitmap.
`timescale 1ns / 1ps
module sharded_bitmap_allocator_top_test;
  import sba_pkg::*;

  localparam int IDLE_LIMIT   = 5000;
  localparam int TAIL_CYCLES  = 200;
  localparam int RANDOM_ITEMS = 832;
  localparam int NUM_SETTINGS = 8;

  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic [HINT_W-1:0]   hint;
    logic [BEGIN_W-1:0]  first_bit;
    logic [END_W-1:0]    end_bit;
    logic [TARGET_W-1:0] target;
  } alloc_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [CBIT_W-1:0]   claimed_bit;
    logic [CWORD_W-1:0]  claimed_word;
    logic [PROBED_W-1:0] words_probed;
    logic                bit_is_set;
  } alloc_res_t;

  class bitmap_shadow;
    word_t            bitmap[MAX_WORDS_DEF];
    logic [CFG_W-1:0] active;
    alloc_res_t       pending_results[$];
    int               errors, accepted, grants, exhausts, dbl_clears;

    function new();
      foreach (bitmap[i]) bitmap[i] = '0;
      active = ACTIVE_RESET;
      errors = 0;
      accepted = 0;
      grants = 0;
      exhausts = 0;
      dbl_clears = 0;
    endfunction

    function int unsigned word_count();
      if (active == 0) return 1;
      if (active > MAX_WORDS_DEF) return MAX_WORDS_DEF;
      return active;
    endfunction

    function word_t below(int unsigned n);
      return (n >= WORD_BITS) ? '1 : ((word_t'(1) << n) - 1);
    endfunction

    function int unsigned lowest_one(word_t v);
      int i;
      for (i = 0; i < WORD_BITS; i++) begin
        if (v[i]) return i;
      end
      return WORD_BITS - 1;
    endfunction

    function int unsigned pick_taken_bit();
      int unsigned words, w, b, k;
      words = word_count();
      w = $urandom_range(words - 1);
      for (k = 0; k < words; k++) begin
        if (bitmap[(w + k) % words] != '0) begin
          w = (w + k) % words;
          b = $urandom_range(WORD_BITS - 1);
          while (!bitmap[w][b]) b = (b + 1) % WORD_BITS;
          return w * WORD_BITS + b;
        end
      end
      return $urandom_range(words * WORD_BITS - 1);
    endfunction

    function void note_request(alloc_req_t r);
      int unsigned words, total, hint, first, last, span, startw, w, p, lo, hi, b;
      word_t avail, cand;
      bit done;
      alloc_res_t e;
      words = word_count();
      total = words * WORD_BITS;
      e = '0;
      e.status = STAT_INVALID;
      done = 0;
      accepted++;
      case (r.func)
        FN_ALLOC_ANY: begin
          e.status = STAT_EXHAUSTED;
          for (p = 0; p < words && !done; p++) begin
            w = (r.hint % words + p) % words;
            if (bitmap[w] != '1) begin
              b = lowest_one(~bitmap[w]);
              bitmap[w][b] = 1'b1;
              e.status = STAT_OK;
              e.claimed_bit = CBIT_W'(w * WORD_BITS + b);
              e.claimed_word = CWORD_W'(w);
              done = 1;
            end
          end
        end
        FN_ALLOC_RANGE: begin
          if (r.first_bit < r.end_bit && r.end_bit <= total) begin
            hint = (r.hint < r.first_bit || r.hint >= r.end_bit) ? r.first_bit : r.hint;
            first = r.first_bit / WORD_BITS;
            last = (r.end_bit - 1) / WORD_BITS;
            span = last - first + 1;
            startw = hint / WORD_BITS;
            e.status = STAT_EXHAUSTED;
            e.words_probed = PROBED_W'(span);
            for (p = 0; p < span && !done; p++) begin
              w = first + (startw - first + p) % span;
              lo = (w == first) ? r.first_bit % WORD_BITS : 0;
              hi = (w == last) ? (r.end_bit - 1) % WORD_BITS + 1 : WORD_BITS;
              avail = ~bitmap[w] & below(hi) & ~below(lo);
              if (avail != '0) begin
                cand = avail;
                if (p == 0 && (avail & ~below(hint % WORD_BITS)) != '0) begin
                  cand = avail & ~below(hint % WORD_BITS);
                end
                b = lowest_one(cand);
                bitmap[w][b] = 1'b1;
                e.status = STAT_OK;
                e.claimed_bit = CBIT_W'(w * WORD_BITS + b);
                e.claimed_word = CWORD_W'(w);
                e.words_probed = PROBED_W'(p + 1);
                done = 1;
              end
            end
          end
        end
        FN_SET_RANGE: begin
          if (r.first_bit < r.end_bit && r.end_bit <= total) begin
            for (b = r.first_bit; b < r.end_bit; b++) bitmap[b / WORD_BITS][b % WORD_BITS] = 1'b1;
            e.status = STAT_OK;
          end
        end
        FN_CLEAR_BIT: begin
          if (r.target < total) begin
            if (!bitmap[r.target / WORD_BITS][r.target % WORD_BITS]) begin
              e.status = STAT_DBL_CLEAR;
            end else begin
              bitmap[r.target / WORD_BITS][r.target % WORD_BITS] = 1'b0;
              e.status = STAT_OK;
            end
          end
        end
        FN_TEST_BIT: begin
          if (r.target < total) begin
            e.status = STAT_OK;
            e.bit_is_set = bitmap[r.target / WORD_BITS][r.target % WORD_BITS];
          end
        end
        default: e.status = STAT_INVALID;
      endcase
      if ((r.func == FN_ALLOC_ANY || r.func == FN_ALLOC_RANGE) && e.status == STAT_OK) grants++;
      if (e.status == STAT_EXHAUSTED) exhausts++;
      if (e.status == STAT_DBL_CLEAR) dbl_clears++;
      pending_results.push_back(e);
    endfunction

    function string show(alloc_res_t r);
      return $sformatf("status=%0d bit=%0d word=%0d probed=%0d set=%0d", r.status,
                       r.claimed_bit, r.claimed_word, r.words_probed, r.bit_is_set);
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(alloc_res_t got);
      alloc_res_t e;
      if (pending_results.size() == 0) begin
        report_mismatch({"result with nothing outstanding: ", show(got)});
        return;
      end
      e = pending_results.pop_front();
      if (got.status !== e.status || got.claimed_bit !== e.claimed_bit ||
          got.claimed_word !== e.claimed_word || got.words_probed !== e.words_probed ||
          got.bit_is_set !== e.bit_is_set) begin
        report_mismatch({"got ", show(got), ", expected ", show(e)});
      end
    endtask
  endclass

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [FUNC_W-1:0]   in_func;
  logic [HINT_W-1:0]   in_hint;
  logic [BEGIN_W-1:0]  in_range_begin;
  logic [END_W-1:0]    in_range_end;
  logic [TARGET_W-1:0] in_target_bit;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [CBIT_W-1:0]   out_claimed_bit;
  logic [CWORD_W-1:0]  out_claimed_word;
  logic [PROBED_W-1:0] out_words_probed;
  logic                out_bit_is_set;
  logic                cfg_we;
  logic [CFG_W-1:0]    cfg_wdata;

  bitmap_shadow shadow;
  int           idle_cycles = 0;
  int           settings_run = 0;

  sharded_bitmap_allocator_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_func          (in_func),
    .in_hint          (in_hint),
    .in_range_begin   (in_range_begin),
    .in_range_end     (in_range_end),
    .in_target_bit    (in_target_bit),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_claimed_bit  (out_claimed_bit),
    .out_claimed_word (out_claimed_word),
    .out_words_probed (out_words_probed),
    .out_bit_is_set   (out_bit_is_set),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (out_valid === 1'b1) begin
        shadow.check_result({out_status, out_claimed_bit, out_claimed_word,
                             out_words_probed, out_bit_is_set});
      end
      if (start && !busy) begin
        shadow.note_request({in_func, in_hint, in_range_begin, in_range_end, in_target_bit});
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (start && !busy)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Watchdog expired: no transaction for %0d cycles.", IDLE_LIMIT);
      $display("sharded_bitmap_allocator_top_test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send(alloc_req_t r);
    start <= 1'b1;
    in_func <= r.func;
    in_hint <= r.hint;
    in_range_begin <= r.first_bit;
    in_range_end <= r.end_bit;
    in_target_bit <= r.target;
    do @(posedge clk); while (busy);
  endtask

  task automatic pause(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (shadow.pending_results.size() != 0 || busy);
  endtask

  task automatic write_words(logic [CFG_W-1:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    shadow.active = v;
    cfg_we <= 1'b0;
  endtask

  function automatic alloc_req_t mk(logic [FUNC_W-1:0] f, int hint, int first_bit,
                                    int end_bit, int target);
    alloc_req_t r;
    r.func = f;
    r.hint = HINT_W'(hint);
    r.first_bit = BEGIN_W'(first_bit);
    r.end_bit = END_W'(end_bit);
    r.target = TARGET_W'(target);
    return r;
  endfunction

  function automatic alloc_req_t random_req();
    alloc_req_t r;
    int unsigned total, sel, len, first_bit;
    total = shadow.word_count() * WORD_BITS;
    sel = $urandom_range(99);
    if (sel < 28) r.func = FN_ALLOC_ANY;
    else if (sel < 48) r.func = FN_ALLOC_RANGE;
    else if (sel < 54) r.func = FN_SET_RANGE;
    else if (sel < 82) r.func = FN_CLEAR_BIT;
    else if (sel < 95) r.func = FN_TEST_BIT;
    else r.func = FUNC_W'($urandom_range(7, 5));
    first_bit = $urandom_range(total - 1);
    if (r.func == FN_SET_RANGE) len = $urandom_range(24, 1);
    else len = ($urandom_range(7) == 0) ? $urandom_range(total, 1) : $urandom_range(160, 1);
    r.first_bit = BEGIN_W'(first_bit);
    r.end_bit = END_W'((first_bit + len > total) ? total : first_bit + len);
    if ($urandom_range(9) == 0) begin
      r.first_bit = BEGIN_W'($urandom_range(4095));
      r.end_bit = END_W'($urandom_range(8191));
    end
    if ($urandom_range(9) < 6 && r.end_bit > r.first_bit) begin
      r.hint = HINT_W'($urandom_range(r.end_bit - 1, r.first_bit));
    end else begin
      r.hint = HINT_W'($urandom_range(4095));
    end
    sel = $urandom_range(9);
    if (r.func == FN_CLEAR_BIT && sel < 6) r.target = TARGET_W'(shadow.pick_taken_bit());
    else if (sel < 9) r.target = TARGET_W'($urandom_range(total - 1));
    else r.target = TARGET_W'($urandom_range(4095));
    return r;
  endfunction

  initial begin
    logic [CFG_W-1:0] settings[NUM_SETTINGS];
    alloc_req_t       directed[$];
    int               per_setting, n;
    shadow = new();
    rst_n = 1'b0;
    start = 1'b0;
    in_func = FN_TEST_BIT;
    in_hint = '0;
    in_range_begin = '0;
    in_range_end = '0;
    in_target_bit = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    drain();

    directed = '{
      mk(FN_TEST_BIT, 0, 0, 0, 0),
      mk(FN_TEST_BIT, 0, 0, 0, 4095),
      mk(FN_CLEAR_BIT, 0, 0, 0, 5),
      mk(FN_ALLOC_ANY, 0, 0, 0, 0),
      mk(FN_ALLOC_ANY, 4095, 0, 0, 0),
      mk(FN_ALLOC_RANGE, 100, 64, 200, 0),
      mk(FN_ALLOC_RANGE, 10, 64, 200, 0),
      mk(FN_ALLOC_RANGE, 300, 300, 300, 0),
      mk(FN_ALLOC_RANGE, 0, 0, 8191, 0),
      mk(FN_SET_RANGE, 0, 4095, 8191, 0),
      mk(FN_SET_RANGE, 0, 0, 4096, 0),
      mk(FN_ALLOC_ANY, 17, 0, 0, 0),
      mk(FN_ALLOC_RANGE, 0, 0, 4096, 0),
      mk(FN_CLEAR_BIT, 0, 0, 0, 4095),
      mk(FN_TEST_BIT, 0, 0, 0, 4095),
      mk(FN_TEST_BIT, 0, 0, 0, 4094),
      mk(FN_ALLOC_RANGE, 4000, 4032, 4096, 0),
      mk(FN_CLEAR_BIT, 0, 0, 0, 4095),
      mk(FN_CLEAR_BIT, 0, 0, 0, 4095),
      mk(FN_CLEAR_BIT, 0, 0, 0, 0),
      mk(FN_ALLOC_RANGE, 0, 0, 1, 0),
      mk(3'd5, 4095, 4095, 8191, 4095),
      mk(3'd6, 0, 0, 0, 0),
      mk(3'd7, 0, 0, 0, 0)
    };
    foreach (directed[i]) send(directed[i]);

    settings = '{7'd1, 7'd0, 7'd3, 7'd127, 7'd9, 7'd2, 7'd40, 7'd64};
    per_setting = RANDOM_ITEMS / NUM_SETTINGS;
    foreach (settings[i]) begin
      write_words(settings[i]);
      settings_run++;
      for (n = 0; n < per_setting; n++) begin
        send(random_req());
        if (i != NUM_SETTINGS - 1 && n % 40 < 28 && $urandom_range(3) == 0) begin
          pause($urandom_range(7, 1));
        end
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (shadow.pending_results.size() != 0) begin
      shadow.report_mismatch($sformatf("%0d results never arrived",
                                       shadow.pending_results.size()));
    end
    $display("Covered %0d transactions over the reset word count and %0d written settings.",
             shadow.accepted, settings_run);
    $display("Allocations granted %0d, exhausted %0d, double clears %0d, mismatches %0d.",
             shadow.grants, shadow.exhausts, shadow.dbl_clears, shadow.errors);
    if (shadow.errors == 0) begin
      $display("sharded_bitmap_allocator_top_test passed");
    end else begin
      $display("sharded_bitmap_allocator_top_test failed");
    end
    $finish;
  end

endmodule
